// ===== rtl/double_context_job_register_file_top_macros.svh =====
// Assertion macros used by the RTL
`ifndef DOUBLE_CONTEXT_JOB_REGISTER_FILE_TOP_MACROS_SVH
`define DOUBLE_CONTEXT_JOB_REGISTER_FILE_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DCJR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define DCJR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dcjr_pkg.sv =====
package dcjr_pkg;

  localparam int NUM_REGS_DEF    = 32;
  localparam int JOB_ID_BITS_DEF = 8;

  localparam int CMD_W  = 3;
  localparam int ADDR_W = 7;
  localparam int DATA_W = 32;
  localparam int CODE_W = 2;
  localparam int JID_W  = 8;

  localparam logic [CMD_W-1:0] CMD_READ    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_COMMIT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STATUS  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DONE    = 3'd5;

  localparam logic [CODE_W-1:0] ACQ_GRANTED = 2'd0;
  localparam logic [CODE_W-1:0] ACQ_FULL    = 2'd1;
  localparam logic [CODE_W-1:0] ACQ_LOCKED  = 2'd2;

  typedef struct packed {
    logic we;
    logic re;
  } mem_req_t;

  typedef struct packed {
    logic [CODE_W-1:0] acquire_code;
    logic [JID_W-1:0]  granted_job_id;
    logic              busy_res;
    logic              addr_error;
  } ctrl_res_t;

endpackage

// ===== rtl/dcjr_mem.sv =====
module dcjr_mem #(
  parameter int DEPTH = 2 * dcjr_pkg::NUM_REGS_DEF,
  parameter int AW    = $clog2(2 * dcjr_pkg::NUM_REGS_DEF)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dcjr_pkg::mem_req_t          req,
  input  logic [AW-1:0]               addr,
  input  logic [dcjr_pkg::DATA_W-1:0] wdata,
  output logic [dcjr_pkg::DATA_W-1:0] rdata
);
  import dcjr_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [DATA_W-1:0] q;
  logic              q_valid;
  logic              re_q;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[addr] <= wdata;
    end
    if (req.re) begin
      q <= mem[addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      q_valid <= 1'b0;
      re_q    <= 1'b0;
    end else begin
      re_q <= req.re;
      if (req.re) begin
        q_valid <= valid[addr];
      end
      if (req.we) begin
        valid[addr] <= 1'b1;
      end
    end
  end

  assign rdata = (re_q && q_valid) ? q : '0;

endmodule

// ===== rtl/dcjr_ctrl.sv =====
`include "double_context_job_register_file_top_macros.svh"

module dcjr_ctrl #(
  parameter int NUM_REGS    = dcjr_pkg::NUM_REGS_DEF,
  parameter int JOB_ID_BITS = dcjr_pkg::JOB_ID_BITS_DEF,
  parameter int AW          = $clog2(2 * dcjr_pkg::NUM_REGS_DEF)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [dcjr_pkg::CMD_W-1:0]  cmd,
  input  logic [dcjr_pkg::ADDR_W-1:0] reg_addr,
  output dcjr_pkg::mem_req_t          req,
  output logic [AW-1:0]               slot,
  output dcjr_pkg::ctrl_res_t         res
);
  import dcjr_pkg::*;

  localparam logic [7:0] NR8  = 8'(NUM_REGS);
  localparam logic [7:0] TOP8 = 8'(3 * NUM_REGS);

  logic                   cfg_sel, cfg_sel_next;
  logic                   act_sel, act_sel_next;
  logic                   locked, locked_next;
  logic [1:0]             pending, pending_next;
  logic [JOB_ID_BITS-1:0] next_job, next_job_next;
  logic [JOB_ID_BITS-1:0] ctx_job [2];
  logic                   grant;

  logic [7:0]             addr8;
  logic [7:0]             sum8;
  logic                   in_range;
  logic [JOB_ID_BITS+JID_W-1:0] jid_ext;

  always_comb begin
    addr8    = {1'b0, reg_addr};
    in_range = addr8 < TOP8;
    if (addr8 < NR8) begin
      sum8 = (cfg_sel ? NR8 : 8'd0) + addr8;
    end else begin
      sum8 = addr8 - NR8;
    end
  end

  assign slot    = sum8[AW-1:0];
  assign jid_ext = {{JID_W{1'b0}}, next_job};

  always_comb begin
    cfg_sel_next  = cfg_sel;
    act_sel_next  = act_sel;
    locked_next   = locked;
    pending_next  = pending;
    next_job_next = next_job;
    grant         = 1'b0;
    req           = '0;
    res           = '0;
    if (accept) begin
      unique case (cmd)
        CMD_READ: begin
          req.re         = in_range;
          res.addr_error = !in_range;
        end
        CMD_WRITE: begin
          req.we         = in_range;
          res.addr_error = !in_range;
        end
        CMD_ACQUIRE: begin
          priority if (pending[1]) begin
            res.acquire_code = ACQ_FULL;
          end else if (locked) begin
            res.acquire_code = ACQ_LOCKED;
          end else begin
            res.acquire_code   = ACQ_GRANTED;
            res.granted_job_id = jid_ext[JID_W-1:0];
            grant              = 1'b1;
            next_job_next      = next_job + 1'b1;
            locked_next        = 1'b1;
          end
        end
        CMD_COMMIT: begin
          if (pending != 2'd3) begin
            pending_next = pending + 2'd1;
          end
          locked_next  = 1'b0;
          cfg_sel_next = !cfg_sel;
        end
        CMD_DONE: begin
          if (pending != 2'd0) begin
            pending_next = pending - 2'd1;
            act_sel_next = !act_sel;
          end
        end
        default: begin
        end
      endcase
    end
    res.busy_res = locked_next || (pending_next != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_sel    <= 1'b0;
      act_sel    <= 1'b0;
      locked     <= 1'b0;
      pending    <= 2'd0;
      next_job   <= '0;
      ctx_job[0] <= '0;
      ctx_job[1] <= '0;
    end else begin
      cfg_sel  <= cfg_sel_next;
      act_sel  <= act_sel_next;
      locked   <= locked_next;
      pending  <= pending_next;
      next_job <= next_job_next;
      if (grant) begin
        ctx_job[cfg_sel] <= next_job;
      end
    end
  end

  `DCJR_ASSERT_NEXT(a_grant_tags_context, clk, rst, grant,
    locked && ctx_job[$past(cfg_sel)] == $past(next_job), "grant did not tag context")
  `DCJR_ASSERT_NEXT(a_commit_flips, clk, rst, accept && cmd == CMD_COMMIT,
    !locked && cfg_sel != $past(cfg_sel) && pending != 2'd0, "commit did not take effect")
  `DCJR_ASSERT_NEXT(a_done_flips, clk, rst,
    accept && cmd == CMD_DONE && pending != 2'd0,
    act_sel != $past(act_sel) && pending == $past(pending) - 2'd1, "job done mishandled")
  `DCJR_ASSERT_NOW(a_err_no_access, clk, rst, res.addr_error,
    !req.we && !req.re, "out of range address reached memory")

endmodule

// ===== rtl/double_context_job_register_file_top.sv =====
// Channel   Ports                                         Handshake
// command   cmd, reg_addr, write_data                     start && !busy
// result    read_data, acquire_code, granted_job_id,      done, one cycle
//           busy_res, addr_error
//
// One item per cycle; each result appears in the cycle after its item, as
// the read of the context memory is registered.
// busy stays low: every item is taken at once, and a write is visible to a
// read in the next cycle.
// Reset clears all job state and the per-entry valid bits; there is no
// clearing pass. The receiver cannot stall.
module double_context_job_register_file_top #(
  parameter int NUM_REGS    = dcjr_pkg::NUM_REGS_DEF,
  parameter int JOB_ID_BITS = dcjr_pkg::JOB_ID_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [dcjr_pkg::CMD_W-1:0]  cmd,
  input  logic [dcjr_pkg::ADDR_W-1:0] reg_addr,
  input  logic [dcjr_pkg::DATA_W-1:0] write_data,
  output logic                        done,
  output logic [dcjr_pkg::DATA_W-1:0] read_data,
  output logic [dcjr_pkg::CODE_W-1:0] acquire_code,
  output logic [dcjr_pkg::JID_W-1:0]  granted_job_id,
  output logic                        busy_res,
  output logic                        addr_error
);
  import dcjr_pkg::*;

  localparam int DEPTH = 2 * NUM_REGS;
  localparam int AW    = $clog2(DEPTH);

  logic      accept;
  mem_req_t  req;
  logic [AW-1:0] slot;
  ctrl_res_t res, res_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  dcjr_ctrl #(
    .NUM_REGS   (NUM_REGS),
    .JOB_ID_BITS(JOB_ID_BITS),
    .AW         (AW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .cmd     (cmd),
    .reg_addr(reg_addr),
    .req     (req),
    .slot    (slot),
    .res     (res)
  );

  dcjr_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .addr (slot),
    .wdata(write_data),
    .rdata(read_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    res_q <= res;
  end

  assign acquire_code   = res_q.acquire_code;
  assign granted_job_id = res_q.granted_job_id;
  assign busy_res       = res_q.busy_res;
  assign addr_error     = res_q.addr_error;

endmodule
